/* design/cvbf_pkg.sv */
// Shared types and constants for the clipped voxel box fill block.
// Holds field widths, command and label codes, register indexes and the
// controller/datapath command and status structs. Depends on nothing.
package cvbf_pkg;

   // Field and port widths
   localparam int COORD_W    = 6;
   localparam int TYPE_W     = 3;
   localparam int LABEL_W    = 2;
   localparam int BOUND_W    = 12;
   localparam int BRUSH_W    = 5;
   localparam int PLANE_W    = 2;
   localparam int HALF_W     = 7;   // clamped brush size and half width
   localparam int SPAN_W     = 8;   // signed square ends before clipping
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Command codes
   localparam logic [TYPE_W-1:0] REQ_BLOCK_SLICE   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_BLOCK_BOUNDED = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_SEGMENT       = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_ERASE         = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ          = 3'd4;

   // Voxel labels
   localparam logic [LABEL_W-1:0] LBL_BACKGROUND = 2'd0;
   localparam logic [LABEL_W-1:0] LBL_BLOCKING   = 2'd1;
   localparam logic [LABEL_W-1:0] LBL_SEGMENT    = 2'd2;

   // Painting planes; the last selector picks no plane and paints nothing
   localparam logic [PLANE_W-1:0] PLANE_XY   = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_XZ   = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_YZ   = 2'd2;
   localparam logic [PLANE_W-1:0] PLANE_NONE = 2'd3;

   // Register indexes (byte address is four times the index)
   localparam logic [REG_IDX_W-1:0] REG_BRUSH_SIZE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_VIEW_PLANE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PROTECT    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_X_BOUNDS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_Y_BOUNDS   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_Z_BOUNDS   = 3'd5;

   // Register reset values
   localparam logic [BRUSH_W-1:0] BRUSH_RESET  = 5'd5;
   localparam logic [BOUND_W-1:0] BOUNDS_RESET = 12'd4032;

   typedef struct packed {
      logic [BRUSH_W-1:0] brush_size;
      logic [PLANE_W-1:0] view_plane;
      logic               protect_segmentation;
      logic [BOUND_W-1:0] x_bounds;
      logic [BOUND_W-1:0] y_bounds;
      logic [BOUND_W-1:0] z_bounds;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic setup;
      logic start_paint;
      logic issue;
      logic fetch;
      logic load_rsp;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic go_paint;
      logic last_voxel;
   } dp_stat_type;

endpackage

/* design/cvbf_req_if.sv */
// Request channel of the clipped voxel box fill block.
// Carries valid, ready and one command beat. Depends on cvbf_pkg.
interface cvbf_req_if;
   logic                           valid;
   logic                           ready;
   logic [cvbf_pkg::TYPE_W-1:0]    req_type;
   logic [cvbf_pkg::COORD_W-1:0]   x_coord;
   logic [cvbf_pkg::COORD_W-1:0]   y_coord;
   logic [cvbf_pkg::COORD_W-1:0]   z_coord;

   modport source (output valid, req_type, x_coord, y_coord, z_coord, input ready);
   modport sink   (input valid, req_type, x_coord, y_coord, z_coord, output ready);
endinterface

/* design/cvbf_rsp_if.sv */
// Response channel of the clipped voxel box fill block.
// Carries valid, ready and one result beat. Depends on cvbf_pkg.
interface cvbf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [cvbf_pkg::LABEL_W-1:0]   voxel_value;

   modport source (output valid, status, voxel_value, input ready);
   modport sink   (input valid, status, voxel_value, output ready);
endinterface

/* design/cvbf_csr.sv */
// Configuration registers of the clipped voxel box fill block.
// APB-style write and read access, zero wait states. Depends on cvbf_pkg.
module cvbf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cvbf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cvbf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cvbf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output cvbf_pkg::cfg_type                   cfg
);

   localparam int DW = cvbf_pkg::CSR_DATA_W;
   localparam int AW = cvbf_pkg::CSR_ADDR_W;
   localparam int BW = cvbf_pkg::BOUND_W;

   cvbf_pkg::cfg_type                 cfg_ff;
   cvbf_pkg::cfg_type                 cfg_in;
   logic                              wr_en;
   logic [cvbf_pkg::REG_IDX_W-1:0]    reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[AW-1:2];
   assign cfg     = cfg_ff;

   // Update the addressed register on a write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            cvbf_pkg::REG_BRUSH_SIZE: cfg_in.brush_size = pwdata[cvbf_pkg::BRUSH_W-1:0];
            cvbf_pkg::REG_VIEW_PLANE: cfg_in.view_plane = pwdata[cvbf_pkg::PLANE_W-1:0];
            cvbf_pkg::REG_PROTECT:    cfg_in.protect_segmentation = pwdata[0];
            cvbf_pkg::REG_X_BOUNDS:   cfg_in.x_bounds = pwdata[BW-1:0];
            cvbf_pkg::REG_Y_BOUNDS:   cfg_in.y_bounds = pwdata[BW-1:0];
            cvbf_pkg::REG_Z_BOUNDS:   cfg_in.z_bounds = pwdata[BW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brush_size           <= cvbf_pkg::BRUSH_RESET;
         cfg_ff.view_plane           <= cvbf_pkg::PLANE_XY;
         cfg_ff.protect_segmentation <= 1'b0;
         cfg_ff.x_bounds             <= cvbf_pkg::BOUNDS_RESET;
         cfg_ff.y_bounds             <= cvbf_pkg::BOUNDS_RESET;
         cfg_ff.z_bounds             <= cvbf_pkg::BOUNDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_idx)
         cvbf_pkg::REG_BRUSH_SIZE: prdata = DW'(cfg_ff.brush_size);
         cvbf_pkg::REG_VIEW_PLANE: prdata = DW'(cfg_ff.view_plane);
         cvbf_pkg::REG_PROTECT:    prdata = DW'(cfg_ff.protect_segmentation);
         cvbf_pkg::REG_X_BOUNDS:   prdata = DW'(cfg_ff.x_bounds);
         cvbf_pkg::REG_Y_BOUNDS:   prdata = DW'(cfg_ff.y_bounds);
         cvbf_pkg::REG_Z_BOUNDS:   prdata = DW'(cfg_ff.z_bounds);
         default:                  prdata = '0;
      endcase
   end

endmodule

/* design/cvbf_ctrl.sv */
// Controller of the clipped voxel box fill block: one-hot state machine
// that sequences clearing, setup, painting, reads and the result beat.
// Depends on cvbf_pkg; drives cvbf_dp through command and status structs.
module cvbf_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  cvbf_pkg::dp_stat_type       stat,
   output cvbf_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_PAINT = 7'b0001000,
      ST_DRAIN = 7'b0010000,
      ST_FETCH = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            priority if (stat.is_read) begin
               state_in = ST_FETCH;
            end else if (stat.go_paint) begin
               cmd.start_paint = 1'b1;
               state_in        = ST_PAINT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PAINT: begin
            cmd.issue = 1'b1;
            if (stat.last_voxel) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Hold the result beat until taken
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded over an untaken beat");

   a_last_voxel_drains: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && stat.last_voxel) |=> (state_ff == ST_DRAIN))
      else $error("last voxel did not lead to drain");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside of done");

endmodule

/* design/cvbf_dp.sv */
// Datapath of the clipped voxel box fill block: request latch, square
// clipping, voxel scan counters, label memory with read-modify-write stage.
// Depends on cvbf_pkg; steered by cvbf_ctrl.
module cvbf_dp #(
   parameter int DIM_X     = 64,
   parameter int DIM_Y     = 64,
   parameter int DIM_Z     = 64,
   parameter int MAX_BRUSH = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cvbf_pkg::cfg_type                 cfg,
   input  logic [cvbf_pkg::TYPE_W-1:0]       req_type,
   input  logic [cvbf_pkg::COORD_W-1:0]      x_coord,
   input  logic [cvbf_pkg::COORD_W-1:0]      y_coord,
   input  logic [cvbf_pkg::COORD_W-1:0]      z_coord,
   input  cvbf_pkg::ctrl_cmd_type            cmd,
   output cvbf_pkg::dp_stat_type             stat,
   output logic                              status,
   output logic [cvbf_pkg::LABEL_W-1:0]      voxel_value
);

   localparam int CW     = cvbf_pkg::COORD_W;
   localparam int BW     = cvbf_pkg::BOUND_W;
   localparam int SW     = cvbf_pkg::SPAN_W;
   localparam int HW     = cvbf_pkg::HALF_W;
   localparam int LW     = cvbf_pkg::LABEL_W;
   localparam int TW     = cvbf_pkg::TYPE_W;
   localparam int XW     = $clog2(DIM_X);
   localparam int YW     = $clog2(DIM_Y);
   localparam int ZW     = $clog2(DIM_Z);
   localparam int ADDR_W = XW + YW + ZW;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [HW-1:0] BRUSH_CAP = HW'(MAX_BRUSH);

   // Request latch
   logic [TW-1:0]     type_ff, type_in;
   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;

   // Axis roles and clipping
   logic [CW-1:0]         ca, co, cd;
   logic [BW-1:0]         ba, bo, bd;
   logic [HW-1:0]         brush_ext, brush_clamp, half;
   logic signed [SW-1:0]  a_lo_raw, a_hi_raw, o_lo_raw, o_hi_raw, d_click;
   logic [CW-1:0]         a_min, a_max, o_min, o_max, d_min, d_max;
   logic                  is_paint, d_ok, span_empty, bounded;

   // Scan counters
   logic [CW-1:0]   a_ff, a_in, o_ff, o_in, d_ff, d_in;
   logic [CW-1:0]   a_hi_ff, a_hi_in, o_lo_ff, o_lo_in, o_hi_ff, o_hi_in;
   logic [CW-1:0]   d_lo_ff, d_lo_in, d_hi_ff, d_hi_in;
   logic [CW-1:0]   vx, vy, vz;

   // Memory and write stage
   logic [LW-1:0]       voxel_mem_ff [DEPTH];
   logic [LW-1:0]       rd_data_ff;
   logic [ADDR_W-1:0]   voxel_addr, click_addr, rd_addr;
   logic                voxel_ok, click_ok;
   logic                wr_vld_ff, wr_vld_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [LW-1:0]       label;
   logic                paint_we, mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [LW-1:0]       mem_wdata;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   // Result
   logic            res_status_ff, res_status_in;
   logic [LW-1:0]   res_value_ff, res_value_in;
   logic            rsp_status_ff, rsp_status_in;
   logic [LW-1:0]   rsp_value_ff, rsp_value_in;

   function automatic logic in_span(input logic signed [SW-1:0] v,
                                    input logic [BW-1:0] b);
      logic signed [SW-1:0] lo;
      logic signed [SW-1:0] hi;
      lo = $signed(SW'(b[CW-1:0]));
      hi = $signed(SW'(b[BW-1:CW]));
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic in_store(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                     input logic [CW-1:0] z);
      return (32'(x) < DIM_X) && (32'(y) < DIM_Y) && (32'(z) < DIM_Z);
   endfunction

   function automatic logic [ADDR_W-1:0] mk_addr(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y,
                                                 input logic [CW-1:0] z);
      return {ZW'(z), YW'(y), XW'(x)};
   endfunction

   // Latch the accepted request
   always_comb begin
      type_in = type_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      if (cmd.load_req) begin
         type_in = req_type;
         cx_in   = x_coord;
         cy_in   = y_coord;
         cz_in   = z_coord;
      end
   end

   // Map plane to abscissa, ordinate and depth axes
   always_comb begin
      unique case (cfg.view_plane)
         cvbf_pkg::PLANE_XZ: begin
            ca = cx_ff;  co = cz_ff;  cd = cy_ff;
            ba = cfg.x_bounds;  bo = cfg.z_bounds;  bd = cfg.y_bounds;
         end
         cvbf_pkg::PLANE_YZ: begin
            ca = cy_ff;  co = cz_ff;  cd = cx_ff;
            ba = cfg.y_bounds;  bo = cfg.z_bounds;  bd = cfg.x_bounds;
         end
         default: begin
            ca = cx_ff;  co = cy_ff;  cd = cz_ff;
            ba = cfg.x_bounds;  bo = cfg.y_bounds;  bd = cfg.z_bounds;
         end
      endcase
   end

   // Clamp brush size and derive the half width
   assign brush_ext = HW'(cfg.brush_size);
   always_comb begin
      priority if (brush_ext == '0) begin
         brush_clamp = HW'(1);
      end else if (brush_ext > BRUSH_CAP) begin
         brush_clamp = BRUSH_CAP;
      end else begin
         brush_clamp = brush_ext;
      end
   end
   assign half = brush_clamp - HW'(1);

   // Square ends, then clip each end that falls outside its axis bounds
   assign a_lo_raw = $signed(SW'(ca)) - $signed(SW'(half));
   assign a_hi_raw = $signed(SW'(ca)) + $signed(SW'(half));
   assign o_lo_raw = $signed(SW'(co)) - $signed(SW'(half));
   assign o_hi_raw = $signed(SW'(co)) + $signed(SW'(half));
   assign d_click  = $signed(SW'(cd));

   assign a_min = in_span(a_lo_raw, ba) ? a_lo_raw[CW-1:0] : ba[CW-1:0];
   assign a_max = in_span(a_hi_raw, ba) ? a_hi_raw[CW-1:0] : ba[BW-1:CW];
   assign o_min = in_span(o_lo_raw, bo) ? o_lo_raw[CW-1:0] : bo[CW-1:0];
   assign o_max = in_span(o_hi_raw, bo) ? o_hi_raw[CW-1:0] : bo[BW-1:CW];

   assign bounded = (type_ff == cvbf_pkg::REQ_BLOCK_BOUNDED);
   assign d_min   = bounded ? bd[CW-1:0]  : cd;
   assign d_max   = bounded ? bd[BW-1:CW] : cd;
   assign d_ok    = in_span(d_click, bd);

   assign is_paint = ((type_ff == cvbf_pkg::REQ_BLOCK_SLICE) ||
                      (type_ff == cvbf_pkg::REQ_BLOCK_BOUNDED) ||
                      (type_ff == cvbf_pkg::REQ_SEGMENT) ||
                      (type_ff == cvbf_pkg::REQ_ERASE)) &&
                     (cfg.view_plane != cvbf_pkg::PLANE_NONE);
   assign span_empty = (a_min > a_max) || (o_min > o_max);

   assign stat.is_read    = (type_ff == cvbf_pkg::REQ_READ);
   assign stat.go_paint   = is_paint & d_ok & ~span_empty;
   assign stat.last_voxel = (a_ff == a_hi_ff) && (o_ff == o_hi_ff) && (d_ff == d_hi_ff);
   assign stat.clear_last = &clr_addr_ff;

   // Load and advance the scan, depth innermost
   always_comb begin
      a_in    = a_ff;     o_in    = o_ff;     d_in    = d_ff;
      a_hi_in = a_hi_ff;  o_lo_in = o_lo_ff;  o_hi_in = o_hi_ff;
      d_lo_in = d_lo_ff;  d_hi_in = d_hi_ff;
      if (cmd.start_paint) begin
         a_in    = a_min;  a_hi_in = a_max;
         o_in    = o_min;  o_lo_in = o_min;  o_hi_in = o_max;
         d_in    = d_min;  d_lo_in = d_min;  d_hi_in = d_max;
      end else if (cmd.issue) begin
         if (d_ff != d_hi_ff) begin
            d_in = d_ff + CW'(1);
         end else begin
            d_in = d_lo_ff;
            if (o_ff != o_hi_ff) begin
               o_in = o_ff + CW'(1);
            end else begin
               o_in = o_lo_ff;
               a_in = a_ff + CW'(1);
            end
         end
      end
   end

   // Map scan position back to x, y, z
   always_comb begin
      unique case (cfg.view_plane)
         cvbf_pkg::PLANE_XZ: begin
            vx = a_ff;  vz = o_ff;  vy = d_ff;
         end
         cvbf_pkg::PLANE_YZ: begin
            vy = a_ff;  vz = o_ff;  vx = d_ff;
         end
         default: begin
            vx = a_ff;  vy = o_ff;  vz = d_ff;
         end
      endcase
   end

   assign voxel_ok   = in_store(vx, vy, vz);
   assign voxel_addr = mk_addr(vx, vy, vz);
   assign click_ok   = in_store(cx_ff, cy_ff, cz_ff);
   assign click_addr = mk_addr(cx_ff, cy_ff, cz_ff);
   assign rd_addr    = cmd.issue ? voxel_addr : click_addr;

   // Write stage: old label arrives in the cycle after the voxel is issued
   assign wr_vld_in  = cmd.issue & voxel_ok;
   assign wr_addr_in = voxel_addr;

   always_comb begin
      unique case (type_ff)
         cvbf_pkg::REQ_SEGMENT: label = cvbf_pkg::LBL_SEGMENT;
         cvbf_pkg::REQ_ERASE:   label = cvbf_pkg::LBL_BACKGROUND;
         default:               label = cvbf_pkg::LBL_BLOCKING;
      endcase
   end

   // Skip protected segmentation voxels
   assign paint_we = wr_vld_ff &
                     ~(cfg.protect_segmentation & (rd_data_ff == cvbf_pkg::LBL_SEGMENT));

   // Clearing sweep takes the write port after reset
   assign mem_we      = cmd.clear_step | paint_we;
   assign mem_waddr   = cmd.clear_step ? clr_addr_ff : wr_addr_ff;
   assign mem_wdata   = cmd.clear_step ? cvbf_pkg::LBL_BACKGROUND : label;
   assign clr_addr_in = cmd.clear_step ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= voxel_mem_ff[rd_addr];
   end

   // Result of the current command, then the result beat register
   always_comb begin
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      if (cmd.setup) begin
         res_status_in = is_paint & ~d_ok;
         res_value_in  = cvbf_pkg::LBL_BACKGROUND;
      end else if (cmd.fetch) begin
         res_value_in  = click_ok ? rd_data_ff : cvbf_pkg::LBL_BACKGROUND;
      end
   end

   assign rsp_status_in = cmd.load_rsp ? res_status_ff : rsp_status_ff;
   assign rsp_value_in  = cmd.load_rsp ? res_value_ff  : rsp_value_ff;
   assign status        = rsp_status_ff;
   assign voxel_value   = rsp_value_ff;

   // Payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      cz_ff         <= cz_in;
      a_ff          <= a_in;
      o_ff          <= o_in;
      d_ff          <= d_in;
      a_hi_ff       <= a_hi_in;
      o_lo_ff       <= o_lo_in;
      o_hi_ff       <= o_hi_in;
      d_lo_ff       <= d_lo_in;
      d_hi_ff       <= d_hi_in;
      wr_addr_ff    <= wr_addr_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff   <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         wr_vld_ff   <= wr_vld_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> ((a_ff <= a_hi_ff) && (o_ff <= o_hi_ff) && (d_ff <= d_hi_ff)))
      else $error("scan counter beyond its clipped end");

   a_no_paint_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !wr_vld_ff)
      else $error("paint write collides with clearing sweep");

   a_write_follows_issue: assert property (@(posedge clock) disable iff (reset)
      wr_vld_ff |-> $past(cmd.issue))
      else $error("paint write without an issued voxel");

endmodule

/* design/clipped_voxel_box_fill.sv */
// Clipped voxel box fill: 3D label store with square brush painting.
// Requests arrive on req_port (valid/ready): paint blocking one slice, paint
// blocking over all bounded slices, paint segmentation, erase, or read one
// voxel. Each request gives exactly one beat on rsp_port: status (1 when a
// paint's depth coordinate is outside its bounds) and voxel_value (reads only).
// Brush size, plane, protection and axis bounds sit in APB registers at byte
// addresses 0, 4, 8, 12, 16, 20; write them only while no request is open.
// Sequence: a paint is accepted, set up, scanned voxel by voxel, drained and
// its result loaded into the beat register; the label memory takes one
// read-modify-write per cycle, so the scan of the square (39 x 39 = 1521 at
// the largest brush) sets the rate. A read or a rejected or empty command
// skips the scan. One request is in work at a time.
// Reset: the registers take their reset values at once, then a clearing
// sweep writes background into every memory row, one per cycle (2**18 rows
// at 64 x 64 x 64); no request is accepted during the sweep, register writes
// are. A stalled result beat holds in its output register; the next request
// is still accepted and worked, and its result waits until the beat is taken.
// Depends on cvbf_pkg, cvbf_req_if, cvbf_rsp_if, cvbf_csr, cvbf_ctrl, cvbf_dp.
module clipped_voxel_box_fill #(
   parameter int DIM_X     = 64,
   parameter int DIM_Y     = 64,
   parameter int DIM_Z     = 64,
   parameter int MAX_BRUSH = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   cvbf_req_if.sink                           req_port,
   cvbf_rsp_if.source                         rsp_port,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cvbf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cvbf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cvbf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   cvbf_pkg::cfg_type          cfg;
   cvbf_pkg::ctrl_cmd_type     cmd;
   cvbf_pkg::dp_stat_type      stat;
   logic                       req_ready;
   logic                       rsp_valid;
   logic                       rsp_status;
   logic [cvbf_pkg::LABEL_W-1:0] rsp_value;

   // Register file
   cvbf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer
   cvbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Clipping, scan and label memory
   cvbf_dp #(
      .DIM_X     (DIM_X),
      .DIM_Y     (DIM_Y),
      .DIM_Z     (DIM_Z),
      .MAX_BRUSH (MAX_BRUSH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_type    (req_port.req_type),
      .x_coord     (req_port.x_coord),
      .y_coord     (req_port.y_coord),
      .z_coord     (req_port.z_coord),
      .cmd         (cmd),
      .stat        (stat),
      .status      (rsp_status),
      .voxel_value (rsp_value)
   );

   assign req_port.ready       = req_ready;
   assign rsp_port.valid       = rsp_valid;
   assign rsp_port.status      = rsp_status;
   assign rsp_port.voxel_value = rsp_value;

endmodule

/* verif/tb_top.sv */
// Self-checking bench for clipped_voxel_box_fill: paint and read commands go in
// on the request channel, register writes on APB, a scoreboard predicts each
// result beat. Depends on cvbf_pkg, cvbf_req_if, cvbf_rsp_if and the DUT.
`timescale 1ns / 1ps

module tb_top;

   localparam int DIM_X       = 64;
   localparam int DIM_Y       = 64;
   localparam int DIM_Z       = 64;
   localparam int MAX_BRUSH   = 20;
   localparam int VOXELS      = DIM_X * DIM_Y * DIM_Z;
   localparam int RANDOM_ITEMS = 366;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int DRAIN_TAIL  = 16;
   localparam int MAX_REPORTS = 40;

   // Widths taken over from the package
   localparam int TYPE_W     = cvbf_pkg::TYPE_W;
   localparam int COORD_W    = cvbf_pkg::COORD_W;
   localparam int LABEL_W    = cvbf_pkg::LABEL_W;
   localparam int BRUSH_W    = cvbf_pkg::BRUSH_W;
   localparam int PLANE_W    = cvbf_pkg::PLANE_W;
   localparam int BOUND_W    = cvbf_pkg::BOUND_W;
   localparam int REG_IDX_W  = cvbf_pkg::REG_IDX_W;
   localparam int CSR_ADDR_W = cvbf_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = cvbf_pkg::CSR_DATA_W;

   // Codes the package leaves unnamed
   localparam logic [TYPE_W-1:0]  REQ_UNUSED_LO = 3'd5;
   localparam logic [TYPE_W-1:0]  REQ_UNUSED_HI = 3'd7;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
      logic [COORD_W-1:0] z_coord;
   } command_type;

   typedef struct packed {
      logic               status;
      logic [LABEL_W-1:0] voxel_value;
   } result_type;

   // Label store shadow, register shadow and the queue of expected beats
   class voxel_scoreboard;
      bit [LABEL_W-1:0] labels [VOXELS];
      bit [BRUSH_W-1:0] brush_size  = cvbf_pkg::BRUSH_RESET;
      bit [PLANE_W-1:0] view_plane  = cvbf_pkg::PLANE_XY;
      bit               protect_seg = 1'b0;
      bit [BOUND_W-1:0] bounds [3]  = '{cvbf_pkg::BOUNDS_RESET, cvbf_pkg::BOUNDS_RESET,
                                        cvbf_pkg::BOUNDS_RESET};
      result_type       expected_results [$];
      int unsigned      error_count = 0;
      int unsigned      beat_count  = 0;

      function void write_register(logic [REG_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            cvbf_pkg::REG_BRUSH_SIZE: brush_size  = value[BRUSH_W-1:0];
            cvbf_pkg::REG_VIEW_PLANE: view_plane  = value[PLANE_W-1:0];
            cvbf_pkg::REG_PROTECT:    protect_seg = value[0];
            cvbf_pkg::REG_X_BOUNDS:   bounds[AXIS_X] = value[BOUND_W-1:0];
            cvbf_pkg::REG_Y_BOUNDS:   bounds[AXIS_Y] = value[BOUND_W-1:0];
            cvbf_pkg::REG_Z_BOUNDS:   bounds[AXIS_Z] = value[BOUND_W-1:0];
            default: ;
         endcase
      endfunction

      function int bound_lo(int axis);
         return int'(bounds[axis][COORD_W-1:0]);
      endfunction

      function int bound_hi(int axis);
         return int'(bounds[axis][BOUND_W-1:COORD_W]);
      endfunction

      function bit in_bounds(int axis, int v);
         return v >= bound_lo(axis) && v <= bound_hi(axis);
      endfunction

      // Flat store position, or -1 when the voxel lies outside the store
      function int voxel_index(int spot [3]);
         if (spot[AXIS_X] < 0 || spot[AXIS_X] >= DIM_X || spot[AXIS_Y] < 0 ||
             spot[AXIS_Y] >= DIM_Y || spot[AXIS_Z] < 0 || spot[AXIS_Z] >= DIM_Z)
            return -1;
         return spot[AXIS_X] + DIM_X * (spot[AXIS_Y] + DIM_Y * spot[AXIS_Z]);
      endfunction

      // Fill the clipped square; returns the reject flag
      function bit paint_square(int click [3], bit all_slices,
                                bit [LABEL_W-1:0] label);
         int axis [3];
         int spot [3];
         int half, a_lo, a_hi, o_lo, o_hi, d_lo, d_hi, a, o, d, pos;
         case (view_plane)
            cvbf_pkg::PLANE_XY: axis = '{AXIS_X, AXIS_Y, AXIS_Z};
            cvbf_pkg::PLANE_XZ: axis = '{AXIS_X, AXIS_Z, AXIS_Y};
            cvbf_pkg::PLANE_YZ: axis = '{AXIS_Y, AXIS_Z, AXIS_X};
            default: return 1'b0;
         endcase
         // zero acts as one, oversize acts as the largest brush
         if (brush_size == 0)
            half = 0;
         else if (brush_size > MAX_BRUSH)
            half = MAX_BRUSH - 1;
         else
            half = int'(brush_size) - 1;

         if (!in_bounds(axis[2], click[axis[2]]))
            return 1'b1;
         d_lo = all_slices ? bound_lo(axis[2]) : click[axis[2]];
         d_hi = all_slices ? bound_hi(axis[2]) : click[axis[2]];

         // replace each end that falls outside its axis bounds
         a_lo = click[axis[0]] - half;
         a_hi = click[axis[0]] + half;
         o_lo = click[axis[1]] - half;
         o_hi = click[axis[1]] + half;
         if (!in_bounds(axis[0], a_lo)) a_lo = bound_lo(axis[0]);
         if (!in_bounds(axis[0], a_hi)) a_hi = bound_hi(axis[0]);
         if (!in_bounds(axis[1], o_lo)) o_lo = bound_lo(axis[1]);
         if (!in_bounds(axis[1], o_hi)) o_hi = bound_hi(axis[1]);

         for (a = a_lo; a <= a_hi; a++) begin
            for (o = o_lo; o <= o_hi; o++) begin
               for (d = d_lo; d <= d_hi; d++) begin
                  spot[axis[0]] = a;
                  spot[axis[1]] = o;
                  spot[axis[2]] = d;
                  pos = voxel_index(spot);
                  if (pos < 0)
                     continue;
                  // protected segmentation voxels keep their label
                  if (protect_seg && labels[pos] == cvbf_pkg::LBL_SEGMENT)
                     continue;
                  labels[pos] = label;
               end
            end
         end
         return 1'b0;
      endfunction

      function result_type predict_result(command_type c);
         result_type r;
         int click [3];
         int pos;
         click = '{int'(c.x_coord), int'(c.y_coord), int'(c.z_coord)};
         r = '0;
         case (c.req_type)
            cvbf_pkg::REQ_BLOCK_SLICE:
               r.status = paint_square(click, 1'b0, cvbf_pkg::LBL_BLOCKING);
            cvbf_pkg::REQ_BLOCK_BOUNDED:
               r.status = paint_square(click, 1'b1, cvbf_pkg::LBL_BLOCKING);
            cvbf_pkg::REQ_SEGMENT:
               r.status = paint_square(click, 1'b0, cvbf_pkg::LBL_SEGMENT);
            cvbf_pkg::REQ_ERASE:
               r.status = paint_square(click, 1'b0, cvbf_pkg::LBL_BACKGROUND);
            cvbf_pkg::REQ_READ: begin
               pos = voxel_index(click);
               if (pos >= 0)
                  r.voxel_value = labels[pos];
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_command(command_type c);
         expected_results.push_back(predict_result(c));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      task report(string what);
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("mismatch at result beat %0d: %s", beat_count, what);
      endtask

      task check_result(result_type got);
         result_type want;
         beat_count++;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected beat, status %0b value %0d",
                             got.status, got.voxel_value));
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0b, want %0b", got.status, want.status));
         if (got.voxel_value !== want.voxel_value)
            report($sformatf("voxel_value %0d, want %0d",
                             got.voxel_value, want.voxel_value));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   cvbf_req_if req_ch();
   cvbf_rsp_if rsp_ch();

   voxel_scoreboard sb = new;

   // Shared stimulus controls
   bit          steady = 1'b0;      // both sides run without idle cycles
   int          hold_request = 0;   // long receiver hold-off, in cycles
   int          focus [3] = '{0, 0, 0};
   command_type last_click = '0;

   clipped_voxel_box_fill #(
      .DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z), .MAX_BRUSH(MAX_BRUSH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_ch),
      .rsp_port(rsp_ch),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   function automatic logic [BOUND_W-1:0] pack_bounds(int lo, int hi);
      return {COORD_W'(hi), COORD_W'(lo)};
   endfunction

   function automatic command_type make_command(logic [TYPE_W-1:0] kind,
                                                int x, int y, int z);
      command_type c;
      c.req_type = kind;
      c.x_coord  = COORD_W'(x);
      c.y_coord  = COORD_W'(y);
      c.z_coord  = COORD_W'(z);
      return c;
   endfunction

   // Mostly near the phase focus so reads land on painted voxels
   function automatic logic [COORD_W-1:0] pick_coord(int axis);
      if ($urandom_range(0, 3) != 0)
         return COORD_W'(focus[axis] + $urandom_range(0, 15));
      return COORD_W'($urandom_range(0, 63));
   endfunction

   function automatic command_type random_command();
      command_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 18)      c.req_type = cvbf_pkg::REQ_BLOCK_SLICE;
      else if (pick < 26) c.req_type = cvbf_pkg::REQ_BLOCK_BOUNDED;
      else if (pick < 40) c.req_type = cvbf_pkg::REQ_SEGMENT;
      else if (pick < 52) c.req_type = cvbf_pkg::REQ_ERASE;
      else if (pick < 95) c.req_type = cvbf_pkg::REQ_READ;
      else c.req_type = TYPE_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      c.x_coord = pick_coord(AXIS_X);
      c.y_coord = pick_coord(AXIS_Y);
      c.z_coord = pick_coord(AXIS_Z);
      // probe around the last painted click half of the time
      if (c.req_type == cvbf_pkg::REQ_READ && $urandom_range(0, 1) == 1) begin
         c.x_coord = last_click.x_coord + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
         c.y_coord = last_click.y_coord + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
         c.z_coord = last_click.z_coord + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
      end
      if (c.req_type < cvbf_pkg::REQ_READ)
         last_click = c;
      return c;
   endfunction

   // APB write: idle cycle, setup, then access until pready
   task automatic csr_write(logic [REG_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_register(index, value);
   endtask

   // Offer one command beat; valid stays high into the next beat unless idling
   task automatic send_cmd(command_type c);
      int idle;
      idle = steady ? 0 : $urandom_range(0, 12);
      if (idle > 0) begin
         req_ch.valid    <= 1'b0;
         req_ch.req_type <= TYPE_W'($urandom);
         req_ch.x_coord  <= COORD_W'($urandom);
         req_ch.y_coord  <= COORD_W'($urandom);
         req_ch.z_coord  <= COORD_W'($urandom);
         repeat (idle) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= c.req_type;
      req_ch.x_coord  <= c.x_coord;
      req_ch.y_coord  <= c.y_coord;
      req_ch.z_coord  <= c.z_coord;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_command(c);
   endtask

   // Drop valid and hold until every expected beat has arrived
   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic start_random_phase();
      logic [BRUSH_W-1:0] brush;
      logic [PLANE_W-1:0] plane;
      logic [BOUND_W-1:0] limits [3];
      int depth_axis, lo, hi, pick, axis;
      pick = $urandom_range(0, 9);
      if (pick < 7)       brush = BRUSH_W'($urandom_range(1, 5));
      else if (pick == 7) brush = '0;
      else                brush = BRUSH_W'($urandom_range(6, 31));
      plane = ($urandom_range(0, 9) == 0) ? cvbf_pkg::PLANE_NONE
                                          : PLANE_W'($urandom_range(0, 2));
      for (axis = 0; axis < 3; axis++) begin
         focus[axis] = $urandom_range(0, 63);
         pick = $urandom_range(0, 9);
         lo = 0;
         hi = 63;
         if (pick == 6 || pick == 7) begin
            lo = $urandom_range(0, 31);
            hi = $urandom_range(lo, 63);
         end else if (pick == 8) begin
            lo = focus[axis];
            hi = (lo + 15 > 63) ? 63 : lo + 15;
         end
         limits[axis] = pack_bounds(lo, hi);
         // any 12-bit value, inverted bounds included
         if (pick == 9)
            limits[axis] = BOUND_W'($urandom_range(0, 4095));
      end
      // keep bounded sweeps of a wide brush to a few slices
      depth_axis = (plane == cvbf_pkg::PLANE_XY) ? AXIS_Z :
                   (plane == cvbf_pkg::PLANE_XZ) ? AXIS_Y : AXIS_X;
      if (brush > BRUSH_W'(5)) begin
         lo = (focus[depth_axis] + $urandom_range(0, 12)) % 64;
         hi = lo + $urandom_range(0, 3);
         if (hi > 63) hi = 63;
         limits[depth_axis] = pack_bounds(lo, hi);
      end
      steady = ($urandom_range(0, 3) == 0);
      csr_write(cvbf_pkg::REG_BRUSH_SIZE, CSR_DATA_W'(brush));
      csr_write(cvbf_pkg::REG_VIEW_PLANE, CSR_DATA_W'(plane));
      csr_write(cvbf_pkg::REG_PROTECT, CSR_DATA_W'($urandom_range(0, 1)));
      csr_write(cvbf_pkg::REG_X_BOUNDS, CSR_DATA_W'(limits[AXIS_X]));
      csr_write(cvbf_pkg::REG_Y_BOUNDS, CSR_DATA_W'(limits[AXIS_Y]));
      csr_write(cvbf_pkg::REG_Z_BOUNDS, CSR_DATA_W'(limits[AXIS_Z]));
   endtask

   // Result sink: random ready gaps, long hold-offs on request, check each beat
   initial begin : result_sink
      int idle;
      result_type beat;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            idle = hold_request;
            hold_request = 0;
         end else if (steady) begin
            idle = 0;
         end else begin
            idle = $urandom_range(0, 12);
         end
         if (idle > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         beat.status      = rsp_ch.status;
         beat.voxel_value = rsp_ch.voxel_value;
         sb.check_result(beat);
      end
   end

   // Hang guard
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int issued, phase, n, i, hold_at, drain_at;
      req_ch.valid    = 1'b0;
      req_ch.req_type = '0;
      req_ch.x_coord  = '0;
      req_ch.y_coord  = '0;
      req_ch.z_coord  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: corners, every label, unused codes, full-depth fill
      send_cmd(make_command(cvbf_pkg::REQ_READ, 0, 0, 0));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_SLICE, 0, 0, 0));
      send_cmd(make_command(cvbf_pkg::REQ_READ, 4, 4, 0));
      send_cmd(make_command(cvbf_pkg::REQ_SEGMENT, 63, 63, 63));
      send_cmd(make_command(cvbf_pkg::REQ_READ, 63, 63, 63));
      send_cmd(make_command(cvbf_pkg::REQ_ERASE, 2, 2, 0));
      send_cmd(make_command(cvbf_pkg::REQ_READ, 0, 0, 0));
      send_cmd(make_command(REQ_UNUSED_LO, 1, 2, 3));
      send_cmd(make_command(REQ_UNUSED_HI, 63, 63, 63));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_BOUNDED, 32, 32, 10));
      send_cmd(make_command(cvbf_pkg::REQ_READ, 32, 32, 63));

      // Protection on, xz plane: bounded fill keeps the segmented slice
      wait_results_drained();
      csr_write(cvbf_pkg::REG_PROTECT, 1);
      csr_write(cvbf_pkg::REG_VIEW_PLANE, CSR_DATA_W'(cvbf_pkg::PLANE_XZ));
      send_cmd(make_command(cvbf_pkg::REQ_SEGMENT, 32, 5, 32));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_BOUNDED, 32, 5, 32));
      send_cmd(make_command(cvbf_pkg::REQ_READ, 32, 5, 32));

      // yz plane, zero brush, depth below and above the x bounds
      wait_results_drained();
      csr_write(cvbf_pkg::REG_PROTECT, 0);
      csr_write(cvbf_pkg::REG_VIEW_PLANE, CSR_DATA_W'(cvbf_pkg::PLANE_YZ));
      csr_write(cvbf_pkg::REG_BRUSH_SIZE, 0);
      csr_write(cvbf_pkg::REG_X_BOUNDS, CSR_DATA_W'(pack_bounds(10, 20)));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_SLICE, 5, 0, 0));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_SLICE, 25, 0, 0));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_SLICE, 10, 0, 0));
      send_cmd(make_command(cvbf_pkg::REQ_READ, 10, 0, 0));

      // Oversize brush: low end above the high bound, both ends past their bounds
      wait_results_drained();
      csr_write(cvbf_pkg::REG_VIEW_PLANE, CSR_DATA_W'(cvbf_pkg::PLANE_XY));
      csr_write(cvbf_pkg::REG_BRUSH_SIZE, 31);
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_SLICE, 40, 30, 7));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_SLICE, 2, 63, 8));
      send_cmd(make_command(cvbf_pkg::REQ_READ, 15, 30, 7));

      // Inverted depth bounds reject; the unused plane paints nothing
      wait_results_drained();
      csr_write(cvbf_pkg::REG_Z_BOUNDS, CSR_DATA_W'(pack_bounds(40, 20)));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_SLICE, 32, 32, 30));
      send_cmd(make_command(cvbf_pkg::REQ_BLOCK_BOUNDED, 32, 32, 30));
      wait_results_drained();
      csr_write(cvbf_pkg::REG_VIEW_PLANE, CSR_DATA_W'(cvbf_pkg::PLANE_NONE));
      send_cmd(make_command(cvbf_pkg::REQ_SEGMENT, 32, 32, 30));

      // Random phases, each with fresh register settings
      issued = 0;
      phase = 0;
      while (issued < RANDOM_ITEMS) begin
         wait_results_drained();
         start_random_phase();
         n = $urandom_range(15, 40);
         hold_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : -1;
         drain_at = $urandom_range(1, n - 1);
         for (i = 0; i < n; i++) begin
            if (i == hold_at)
               hold_request = $urandom_range(250, 400);
            if (i == drain_at)
               wait_results_drained();
            send_cmd(random_command());
         end
         issued += n;
         phase++;
      end

      // Drain, then watch the tail for stray beats
      wait_results_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
